### hw/rtl/salc_pkg.sv
// Shared widths, register indexes and result codes for the set-associative LRU cache model.
package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 4;
    localparam int MAX_WAYS_DEF     = 4;
    localparam int AGE_WIDTH_DEF    = 32;

    localparam int ADDR_W       = 32;
    localparam int CNT_W        = 32;
    localparam int SET_BITS_W   = 3;
    localparam int BLOCK_BITS_W = 5;
    localparam int WAYS_W       = 3;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

endpackage

### hw/rtl/set_associative_lru_cache_model.sv
// Top level: set-associative cache with LRU replacement, one way scanned per cycle.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   i_address
//   out       output     o_out_valid / i_out_stall o_outcome, o_hits_total,
//                                                  o_misses_total, o_evictions_total
//   cfg       input      i_cfg_wr_en               i_cfg_index, i_cfg_wdata
//
// From input accept to result valid a beat passes the address split, a way scan and a
// final line write; the single tag compare / age unit visits one line per cycle.
// The result sits in the output register until taken; input stays stalled until then.
// After reset a clearing pass over all 2^(set index bits + way index bits) lines
// (64 at default sizes) invalidates every line before the first beat is taken.
module set_associative_lru_cache_model
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int AGE_WIDTH    = AGE_WIDTH_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [ADDR_W-1:0]     i_address,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_outcome,
    output logic [CNT_W-1:0]      o_hits_total,
    output logic [CNT_W-1:0]      o_misses_total,
    output logic [CNT_W-1:0]      o_evictions_total
);

    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LINE_AW = SET_W + WAY_W;

    typedef struct packed {
        logic                 valid;
        logic [ADDR_W-1:0]    tag;
        logic [AGE_WIDTH-1:0] age;
    } t_line;

    localparam int LINE_W = $bits(t_line);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_PREP  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_FINAL = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state                  r_state, n_state;
    logic [LINE_AW-1:0]      r_clr_addr;
    logic [SET_BITS_W-1:0]   r_set_bits;
    logic [BLOCK_BITS_W-1:0] r_block_bits;
    logic [WAYS_W-1:0]       r_ways;
    logic [ADDR_W-1:0]       r_addr;
    logic [SET_W-1:0]        r_set;
    logic [ADDR_W-1:0]       r_tag;
    logic [WAY_W-1:0]        r_last;
    logic [WAY_W-1:0]        r_way;
    logic                    r_found;
    logic [WAY_W-1:0]        r_hit_way;
    logic                    r_inv_found;
    logic [WAY_W-1:0]        r_inv_way;
    logic [AGE_WIDTH-1:0]    r_best;
    logic [WAY_W-1:0]        r_vict;
    t_outcome                r_outcome;
    logic [CNT_W-1:0]        r_hits;
    logic [CNT_W-1:0]        r_misses;
    logic [CNT_W-1:0]        r_evicts;

    logic [ADDR_W-1:0]     shifted;
    logic [SET_BITS_W-1:0] sb;
    logic [ADDR_W-1:0]     set_mask;
    logic [SET_W-1:0]      prep_set;
    logic [ADDR_W-1:0]     prep_tag;
    logic [WAY_W-1:0]      prep_last;

    logic [LINE_W-1:0]    rd_raw;
    t_line                rd_line;
    logic [AGE_WIDTH-1:0] aged;
    logic                 hit_here;
    logic [WAY_W-1:0]     fin_way;

    logic               wr_en;
    logic [LINE_AW-1:0] wr_addr;
    t_line              wr_line;
    logic [LINE_AW-1:0] rd_addr;

    // address split
    always_comb begin
        shifted  = r_addr >> r_block_bits;
        sb       = (32'(r_set_bits) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : r_set_bits;
        set_mask = ~({ADDR_W{1'b1}} << sb);
        prep_set = SET_W'(shifted & set_mask);
        prep_tag = shifted >> sb;
        if (r_ways == '0) begin
            prep_last = '0;
        end else if (32'(r_ways) > MAX_WAYS) begin
            prep_last = WAY_W'(MAX_WAYS - 1);
        end else begin
            prep_last = WAY_W'(r_ways - WAYS_W'(1));
        end
    end

    // per-way compare and age
    always_comb begin
        rd_line  = t_line'(rd_raw);
        aged     = rd_line.age;
        if (rd_line.valid && !(&rd_line.age)) begin
            aged = rd_line.age + AGE_WIDTH'(1);
        end
        hit_here = rd_line.valid && (rd_line.tag == r_tag) && !r_found;
        fin_way  = r_found ? r_hit_way : (r_inv_found ? r_inv_way : r_vict);
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_line = '0;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_SCAN: begin
                wr_en   = rd_line.valid;
                wr_addr = {r_set, r_way};
                wr_line = '{valid: rd_line.valid, tag: rd_line.tag, age: aged};
            end
            S_FINAL: begin
                wr_en   = 1'b1;
                wr_addr = {r_set, fin_way};
                wr_line = '{valid: 1'b1, tag: r_tag, age: '0};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
        rd_addr = (r_state == S_PREP) ? {prep_set, WAY_W'(0)}
                                      : {r_set, r_way + WAY_W'(1)};
    end

    salc_line_ram #(
        .AW (LINE_AW),
        .DW (LINE_W)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (LINE_W'(wr_line)),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_raw)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (&r_clr_addr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_PREP;
            end
            S_PREP: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_way == r_last) n_state = S_FINAL;
            end
            S_FINAL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= WAYS_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_SET_BITS:   r_set_bits   <= i_cfg_wdata[SET_BITS_W-1:0];
                REG_BLOCK_BITS: r_block_bits <= i_cfg_wdata[BLOCK_BITS_W-1:0];
                REG_WAYS:       r_ways       <= i_cfg_wdata[WAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_way      <= '0;
            r_hits     <= '0;
            r_misses   <= '0;
            r_evicts   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + LINE_AW'(1);
                end
                S_IDLE: begin
                    r_addr <= i_address;
                end
                S_PREP: begin
                    r_set       <= prep_set;
                    r_tag       <= prep_tag;
                    r_last      <= prep_last;
                    r_way       <= '0;
                    r_found     <= 1'b0;
                    r_inv_found <= 1'b0;
                end
                S_SCAN: begin
                    if (hit_here) begin
                        r_found   <= 1'b1;
                        r_hit_way <= r_way;
                    end
                    if (!rd_line.valid && !r_inv_found) begin
                        r_inv_found <= 1'b1;
                        r_inv_way   <= r_way;
                    end
                    if (r_way == '0 || aged > r_best) begin
                        r_best <= aged;
                        r_vict <= r_way;
                    end
                    r_way <= r_way + WAY_W'(1);
                end
                S_FINAL: begin
                    if (r_found) begin
                        r_outcome <= OUT_HIT;
                        if (!(&r_hits)) r_hits <= r_hits + CNT_W'(1);
                    end else begin
                        if (!(&r_misses)) r_misses <= r_misses + CNT_W'(1);
                        if (r_inv_found) begin
                            r_outcome <= OUT_FILL;
                        end else begin
                            r_outcome <= OUT_EVICT;
                            if (!(&r_evicts)) r_evicts <= r_evicts + CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = (r_state == S_OUT);
    assign o_outcome         = r_outcome;
    assign o_hits_total      = r_hits;
    assign o_misses_total    = r_misses;
    assign o_evictions_total = r_evicts;

    a_evict_le_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evicts <= r_misses)
        else $error("eviction total exceeds miss total");

    a_accept_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_PREP))
        else $error("accepted beat did not start address split");

    a_way_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_way <= r_last))
        else $error("way scan ran past last way in use");

    a_evict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && !r_found && !r_inv_found)
            |=> (r_outcome == OUT_EVICT && r_state == S_OUT))
        else $error("full set miss not reported as eviction");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && r_found && !(&r_hits)) |=> (r_hits == $past(r_hits) + CNT_W'(1)))
        else $error("hit total not advanced on hit");

endmodule

### hw/rtl/salc_line_ram.sv
// Line store: one write port, one read port with registered read data.
module salc_line_ram
#(
    parameter int AW = 6,
    parameter int DW = 65
)
(
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### tb/tb_set_associative_lru_cache_model.sv
// Self-checking testbench for the set-associative LRU cache model.
module tb_set_associative_lru_cache_model;
    import salc_pkg::*;

    localparam int WAYS  = MAX_WAYS_DEF;
    localparam int LINES = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;

    typedef struct {
        t_outcome         outcome;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evicts;
    } access_result_t;

    class lru_cache_tracker;
        logic [SET_BITS_W-1:0]   set_bits_r;
        logic [BLOCK_BITS_W-1:0] block_bits_r;
        logic [WAYS_W-1:0]       ways_r;
        bit                      line_valid[LINES];
        logic [31:0]             line_tag[LINES];
        logic [31:0]             line_age[LINES];
        logic [CNT_W-1:0]        hit_cnt;
        logic [CNT_W-1:0]        miss_cnt;
        logic [CNT_W-1:0]        evict_cnt;
        access_result_t          expected_q[$];
        int                      errors;

        function new();
            set_bits_r   = '0;
            block_bits_r = '0;
            ways_r       = 3'd1;
            for (int i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '1;
                line_age[i]   = '0;
            end
            hit_cnt   = '0;
            miss_cnt  = '0;
            evict_cnt = '0;
            errors    = 0;
        endfunction

        function logic [31:0] bump(logic [31:0] v);
            return (v == '1) ? v : v + 32'd1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SET_BITS:   set_bits_r   = data[SET_BITS_W-1:0];
                REG_BLOCK_BITS: block_bits_r = data[BLOCK_BITS_W-1:0];
                REG_WAYS:       ways_r       = data[WAYS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_access(logic [ADDR_W-1:0] addr);
            logic [63:0]    shifted;
            logic [63:0]    tag_wide;
            logic [31:0]    tag;
            logic [31:0]    best;
            int             sb;
            int             nw;
            int             base;
            int             victim;
            int             w;
            bit             found;
            bit             filled;
            access_result_t r;
            sb = (set_bits_r > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(set_bits_r);
            nw = (ways_r == 0) ? 1 : (ways_r > MAX_WAYS_DEF) ? MAX_WAYS_DEF : int'(ways_r);
            shifted  = {32'd0, addr} >> block_bits_r;
            tag_wide = shifted >> sb;
            tag      = tag_wide[31:0];
            base     = int'(shifted & ((64'd1 << sb) - 64'd1)) * WAYS;
            found    = 1'b0;
            filled   = 1'b0;

            for (w = 0; w < nw; w++)
                if (line_valid[base + w])
                    line_age[base + w] = bump(line_age[base + w]);

            for (w = 0; w < nw && !found; w++) begin
                if (line_valid[base + w] && line_tag[base + w] == tag) begin
                    line_age[base + w] = '0;
                    found = 1'b1;
                end
            end

            if (found) begin
                r.outcome = OUT_HIT;
                hit_cnt   = bump(hit_cnt);
            end else begin
                miss_cnt = bump(miss_cnt);
                for (w = 0; w < nw && !filled; w++) begin
                    if (!line_valid[base + w]) begin
                        line_valid[base + w] = 1'b1;
                        line_tag[base + w]   = tag;
                        line_age[base + w]   = '0;
                        filled = 1'b1;
                    end
                end
                if (filled) begin
                    r.outcome = OUT_FILL;
                end else begin
                    r.outcome = OUT_EVICT;
                    evict_cnt = bump(evict_cnt);
                    victim = 0;
                    best   = line_age[base];
                    for (w = 1; w < nw; w++) begin
                        if (line_age[base + w] > best) begin
                            best   = line_age[base + w];
                            victim = w;
                        end
                    end
                    line_tag[base + victim] = tag;
                    line_age[base + victim] = '0;
                end
            end
            r.hits   = hit_cnt;
            r.misses = miss_cnt;
            r.evicts = evict_cnt;
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (act !== exp) begin
                $display("%0t %s expected %0h actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] outcome, logic [CNT_W-1:0] hits,
                                   logic [CNT_W-1:0] misses, logic [CNT_W-1:0] evicts);
            access_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t result beat with none expected: outcome %0d", $time, outcome);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare_field("outcome", 32'(e.outcome), 32'(outcome));
            compare_field("hits_total", e.hits, hits);
            compare_field("misses_total", e.misses, misses);
            compare_field("evictions_total", e.evicts, evicts);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [ADDR_W-1:0]     i_address;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [1:0]            o_outcome;
    logic [CNT_W-1:0]      o_hits_total;
    logic [CNT_W-1:0]      o_misses_total;
    logic [CNT_W-1:0]      o_evictions_total;

    lru_cache_tracker tracker = new();
    bit gaps_on;
    bit stall_on;
    bit hold_req;

    set_associative_lru_cache_model i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_address         (i_address),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_outcome         (o_outcome),
        .o_hits_total      (o_hits_total),
        .o_misses_total    (o_misses_total),
        .o_evictions_total (o_evictions_total)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            tracker.note_access(i_address);
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.check_result(o_outcome, o_hits_total, o_misses_total, o_evictions_total);
    end

    // result side: short random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_access(input logic [ADDR_W-1:0] addr);
        i_in_valid <= 1'b1;
        i_address  <= addr;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic configure(input logic [SET_BITS_W-1:0] sb, input logic [BLOCK_BITS_W-1:0] bb,
                             input logic [WAYS_W-1:0] nw);
        logic [CFG_DATA_W-1:0] data;
        drain();
        repeat (4) @(posedge i_clk);
        data = {2'($urandom_range(0, 3)), sb};
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= REG_SET_BITS;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        tracker.write_reg(REG_SET_BITS, data);
        i_cfg_index <= REG_BLOCK_BITS;
        i_cfg_wdata <= bb;
        @(posedge i_clk);
        tracker.write_reg(REG_BLOCK_BITS, bb);
        data = {2'($urandom_range(0, 3)), nw};
        i_cfg_index <= REG_WAYS;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        tracker.write_reg(REG_WAYS, data);
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly reuse of a small address pool crowded into two sets, plus raw random addresses
    task automatic run_phase(input int n, input logic [SET_BITS_W-1:0] sb,
                             input logic [BLOCK_BITS_W-1:0] bb, input logic [WAYS_W-1:0] nw,
                             input bit with_hold, input bit with_pause);
        logic [ADDR_W-1:0] pool[12];
        logic [63:0]       line_addr;
        logic [ADDR_W-1:0] offset_mask;
        int                pool_n;
        int                sbe;
        configure(sb, bb, nw);
        sbe         = (sb > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(sb);
        offset_mask = 32'((64'd1 << bb) - 64'd1);
        pool_n      = $urandom_range(2, 12);
        for (int k = 0; k < pool_n; k++) begin
            line_addr = ({32'd0, 32'($urandom)} << (sbe + bb))
                      | (64'($urandom_range(0, 1)) << bb);
            pool[k] = line_addr[31:0];
        end
        for (int i = 0; i < n; i++) begin
            if (i == n / 2 && with_hold)
                hold_req = 1'b1;
            if (i == n / 2 && with_pause)
                drain();
            if ($urandom_range(0, 9) < 7)
                send_access(pool[$urandom_range(0, pool_n - 1)] ^ (32'($urandom) & offset_mask));
            else
                send_access(32'($urandom));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= REG_SET_BITS;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_address   <= '0;
        i_out_stall <= 1'b0;
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        hold_req = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one way, no set bits, no offset
        send_access(32'h0000_0000);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'hFFFF_FFFF);

        // two ways in set 1: fill, fill, hit, evict LRU, evict again
        configure(3'd2, 5'd4, 3'd2);
        send_access(32'h0000_0150);
        send_access(32'h0000_0253);
        send_access(32'h0000_015F);
        send_access(32'h0000_0090);
        send_access(32'h0000_0253);

        // set bits saturate, zero ways acts as one, huge offset leaves tag zero
        configure(3'd7, 5'd31, 3'd0);
        send_access(32'h8000_0000);
        send_access(32'h0000_0000);
        send_access(32'h8000_0000);
        send_access(32'h7FFF_FFFF);

        // ways saturate, offset plus set bits reach 32
        configure(3'd4, 5'd28, 3'd7);
        send_access(32'hF000_0000);
        send_access(32'h1234_5678);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0001);

        gaps_on  = 1'b1;
        stall_on = 1'b1;
        run_phase(80, 3'd4, 5'd0, 3'd4, 1'b0, 1'b0);
        run_phase(80, 3'd0, 5'd0, 3'd1, 1'b0, 1'b0);
        run_phase(80, 3'd2, 5'd3, 3'd3, 1'b1, 1'b0);
        run_phase(80, 3'd7, 5'd31, 3'd7, 1'b0, 1'b0);
        run_phase(80, 3'd1, 5'd2, 3'd0, 1'b0, 1'b1);
        run_phase(80, 3'd4, 5'd28, 3'd4, 1'b0, 1'b0);
        for (int p = 0; p < 3; p++)
            run_phase(80, 3'($urandom_range(0, 7)),
                      5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(0, 6)),
                      3'($urandom_range(0, 7)), 1'b0, 1'b0);

        gaps_on  = 1'b0;
        stall_on = 1'b0;
        run_phase(80, 3'd3, 5'd4, 3'd2, 1'b0, 1'b0);

        drain();
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### set_associative_lru_cache_model.f
hw/rtl/salc_pkg.sv
hw/rtl/salc_line_ram.sv
hw/rtl/set_associative_lru_cache_model.sv
tb/tb_set_associative_lru_cache_model.sv
